// File: hdl/phich_pending_ack_tracker_core_macros.svh
// Assertion macros for the PHICH pending-ack tracker.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef PHICH_PENDING_ACK_TRACKER_CORE_MACROS_SVH
`define PHICH_PENDING_ACK_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PPAT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PPAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ppat_pkg.sv
// Shared types, constants and timing tables for the PHICH pending-ack tracker.
// No dependencies; imported by ppat_ram and phich_pending_ack_tracker_core.
`timescale 1ns / 1ps

package ppat_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam int TTI_W       = 14;
  localparam int PRB_W       = 7;
  localparam int DMRS_W      = 3;
  localparam int ENTRY_W     = PRB_W + DMRS_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 32;

  localparam int TTI_WRAP_INT = 10240;
  localparam logic [TTI_W:0] TTI_WRAP = (TTI_W + 1)'(TTI_WRAP_INT);

  // Reciprocal scaling used for modulo-by-constant.
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP10     = (1 << RECIP_SHIFT) / 10;

  localparam logic       FRAME_FDD         = 1'b0;
  localparam logic [3:0] FDD_ACK_DELAY_RST = 4'd4;

  typedef enum logic [1:0] {
    OP_ARM   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_QUERY = 2'd2,
    OP_PHICH = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_TYPE    = 2'd0,
    CFG_TDD_CONFIG    = 2'd1,
    CFG_FDD_ACK_DELAY = 2'd2
  } cfg_idx_t;

  // Input beat, last field in the lowest bits.
  typedef struct packed {
    logic [3:0]        pad;
    logic              decode_error;
    logic              harq_ack;
    logic [DMRS_W-1:0] dmrs_shift;
    logic [PRB_W-1:0]  prb_lowest;
    logic [TTI_W-1:0]  tti;
    op_t               opcode;
  } in_beat_t;

  // Result beat, last field in the lowest bits.
  typedef struct packed {
    logic [3:0]        pad;
    logic              any_pending;
    logic [TTI_W-1:0]  next_tti;
    logic              rearmed;
    logic              handled;
    logic [DMRS_W-1:0] stored_dmrs;
    logic [PRB_W-1:0]  stored_prb;
    logic              entry_pending;
  } out_beat_t;

  // PUSCH offset per UL/DL configuration and subframe; row 7 unused.
  localparam logic [2:0] PUSCH_K [0:7][0:9] = '{
    '{3'd4, 3'd6, 3'd0, 3'd0, 3'd0, 3'd4, 3'd6, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd6, 3'd0, 3'd0, 3'd4, 3'd0, 3'd6, 3'd0, 3'd0, 3'd4},
    '{3'd0, 3'd0, 3'd0, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd4, 3'd0},
    '{3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd4, 3'd4},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd4, 3'd4},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd4, 3'd0},
    '{3'd7, 3'd7, 3'd0, 3'd0, 3'd0, 3'd7, 3'd7, 3'd0, 3'd0, 3'd5},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
  };

  // PHICH offset per UL/DL configuration and PUSCH subframe; row 7 unused.
  localparam logic [2:0] PHICH_K [0:7][0:9] = '{
    '{3'd0, 3'd0, 3'd4, 3'd7, 3'd6, 3'd0, 3'd0, 3'd4, 3'd7, 3'd6},
    '{3'd0, 3'd0, 3'd4, 3'd6, 3'd0, 3'd0, 3'd0, 3'd4, 3'd6, 3'd0},
    '{3'd0, 3'd0, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0, 3'd6, 3'd0, 3'd0},
    '{3'd0, 3'd0, 3'd6, 3'd6, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd0, 3'd6, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd0, 3'd6, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd0, 3'd0, 3'd4, 3'd6, 3'd6, 3'd0, 3'd0, 3'd4, 3'd7, 3'd0},
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
  };

endpackage

// File: hdl/ppat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on ppat_pkg for its parameter defaults; no other modules.
`timescale 1ns / 1ps

module ppat_ram
  import ppat_pkg::*;
#(
  parameter int WIDTH  = ENTRY_W,
  parameter int DEPTH  = TABLE_DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/phich_pending_ack_tracker_core.sv
// Top level of the PHICH pending-ack tracker: stream ports, entry table, timing.
// Depends on ppat_pkg, ppat_ram and phich_pending_ack_tracker_core_macros.svh.
`timescale 1ns / 1ps
`include "phich_pending_ack_tracker_core_macros.svh"

// Tracks pending uplink HARQ acknowledgements in a table of TABLE_DEPTH entries,
// addressed by TTI modulo TABLE_DEPTH (a TTI of 10240 or more is first reduced
// by 10240). Each input beat carries one operation: arm an entry with PRB and
// DMRS shift, clear it, query it, or apply a PHICH outcome. An outcome on an
// armed entry clears it; a NACK without decode error first copies it to the
// next PHICH TTI (TTI plus the FDD delay, or the PUSCH then PHICH timing tables
// for TDD, modulo 10240), and a clear of the same slot wins. Every beat gives
// exactly one result beat, reporting the entry as it was before the operation
// and whether any entry is armed afterwards. The block takes one beat per
// cycle while results are taken. A beat passes two register stages: the input
// register, with the entry RAM read taken beside it on the accepting edge, and
// the result register, which drives out_tvalid and out_tdata.
// The input stalls only while stage 1 holds a beat and the result register holds
// one that is not taken. Reset needs no clearing pass: armed flags and per-entry
// written bits sit in flip-flops, so entries never written read as zero.
// Configuration writes are always accepted and should be made while idle.
module phich_pending_ack_tracker_core
  import ppat_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input beats
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [1:0] opcode, [15:2] tti, [22:16] prb_lowest, [25:23] dmrs_shift,
  // [26] harq_ack, [27] decode_error, [31:28] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Result beats
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] entry_pending, [7:1] stored_prb, [10:8] stored_dmrs, [11] handled,
  // [12] rearmed, [26:13] next_tti, [27] any_pending, [31:28] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SW         = $clog2(TABLE_DEPTH);
  localparam int RecipDepth = (1 << RECIP_SHIFT) / TABLE_DEPTH;
  localparam int AdjWrap    = (TABLE_DEPTH - (TTI_WRAP_INT % TABLE_DEPTH)) % TABLE_DEPTH;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic       frame_type_r;
  logic [2:0] tdd_config_r;
  logic [3:0] fdd_ack_delay_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_type_r    <= FRAME_FDD;
      tdd_config_r    <= 3'd0;
      fdd_ack_delay_r <= FDD_ACK_DELAY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_TYPE:    frame_type_r    <= cfg_data[0];
        CFG_TDD_CONFIG:    tdd_config_r    <= cfg_data[2:0];
        CFG_FDD_ACK_DELAY: fdd_ack_delay_r <= cfg_data;
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic advance;
  logic accept;

  // Stage 1 moves into the result register when that register is free or draining.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: reduce the TTI, derive slot and subframe by reciprocal multiply
  // ---------------------------------------------------------------------------
  in_beat_t         in_beat;
  logic [TTI_W-1:0] tti_in;
  logic [TTI_W-1:0] tti_wrap;
  logic [30:0]      prod_depth;
  logic [30:0]      prod_ten;
  logic [TTI_W-1:0] rem_depth;
  logic [TTI_W-1:0] rem_ten;
  logic [TTI_W-1:0] rem_depth_fix;
  logic [TTI_W-1:0] rem_ten_fix;
  logic [SW-1:0]    slot_in;
  logic [3:0]       sf_in;

  assign in_beat  = in_beat_t'(in_tdata);
  assign tti_in   = in_beat.tti;
  assign tti_wrap = ({1'b0, tti_in} >= TTI_WRAP) ? TTI_W'({1'b0, tti_in} - TTI_WRAP) : tti_in;

  // Quotient estimate is exact or one low; one compare-subtract corrects it.
  assign prod_depth = 31'(tti_wrap) * 31'(RecipDepth);
  assign prod_ten   = 31'(tti_wrap) * 31'(RECIP10);
  assign rem_depth  = tti_wrap - TTI_W'(TTI_W'(prod_depth[30:RECIP_SHIFT]) * TTI_W'(TABLE_DEPTH));
  assign rem_ten    = tti_wrap - TTI_W'(TTI_W'(prod_ten[30:RECIP_SHIFT]) * TTI_W'(10));
  assign rem_depth_fix = (rem_depth >= TTI_W'(TABLE_DEPTH)) ? rem_depth - TTI_W'(TABLE_DEPTH)
                                                            : rem_depth;
  assign rem_ten_fix   = (rem_ten >= TTI_W'(10)) ? rem_ten - TTI_W'(10) : rem_ten;
  assign slot_in       = rem_depth_fix[SW-1:0];
  assign sf_in         = rem_ten_fix[3:0];

  // Stage 1 registers
  op_t               op_r;
  logic [TTI_W-1:0]  tti_r;
  logic [SW-1:0]     slot_r;
  logic [3:0]        sf_r;
  logic [PRB_W-1:0]  prb_r;
  logic [DMRS_W-1:0] dmrs_r;
  logic              ack_r;
  logic              err_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_beat.opcode;
      tti_r  <= tti_wrap;
      slot_r <= slot_in;
      sf_r   <= sf_in;
      prb_r  <= in_beat.prb_lowest;
      dmrs_r <= in_beat.dmrs_shift;
      ack_r  <= in_beat.harq_ack;
      err_r  <= in_beat.decode_error;
    end
  end

  // ---------------------------------------------------------------------------
  // Entry table: armed flags and written bits in flops, payload in RAM
  // ---------------------------------------------------------------------------
  logic [TABLE_DEPTH-1:0] flags_r;
  logic [TABLE_DEPTH-1:0] flags_nxt;
  logic [TABLE_DEPTH-1:0] written_r;
  logic [TABLE_DEPTH-1:0] written_nxt;
  logic                   wr_en_c;
  logic [SW-1:0]          wr_addr_c;
  logic [ENTRY_W-1:0]     wr_data_c;
  logic                   ram_wr_en;
  logic [ENTRY_W-1:0]     ram_rd_data;

  assign ram_wr_en = wr_en_c && advance;

  ppat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH),
    .ADDR_W(SW)
  ) u_entry_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(wr_addr_c),
    .wr_data(wr_data_c),
    .rd_en  (accept),
    .rd_addr(slot_in),
    .rd_data(ram_rd_data)
  );

  // Hold the last payload write; it covers a read taken on the same edge.
  logic               byp_valid_r;
  logic [SW-1:0]      byp_addr_r;
  logic [ENTRY_W-1:0] byp_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_valid_r <= 1'b0;
      flags_r     <= '0;
      written_r   <= '0;
    end else if (advance) begin
      flags_r   <= flags_nxt;
      written_r <= written_nxt;
      if (wr_en_c) begin
        byp_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_wr_en) begin
      byp_addr_r <= wr_addr_c;
      byp_data_r <= wr_data_c;
    end
  end

  logic               was_armed;
  logic [ENTRY_W-1:0] old_entry;

  assign was_armed = flags_r[slot_r];

  always_comb begin
    if (!written_r[slot_r]) begin
      old_entry = '0;
    end else if (byp_valid_r && (byp_addr_r == slot_r)) begin
      old_entry = byp_data_r;
    end else begin
      old_entry = ram_rd_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Next PHICH TTI and its slot
  // ---------------------------------------------------------------------------
  logic [2:0]       k_pusch;
  logic [2:0]       k_phich;
  logic [4:0]       sf_up_sum;
  logic [3:0]       sf_up;
  logic [3:0]       delta;
  logic [TTI_W:0]   tti_sum;
  logic             tti_wrapped;
  logic [TTI_W-1:0] next_tti_c;
  logic [SW+1:0]    ns_a0;
  logic [SW+1:0]    ns_a1;
  logic [SW+1:0]    ns_a2;
  logic [SW+1:0]    ns_b0;
  logic [SW+1:0]    ns_b1;
  logic [SW-1:0]    next_slot;

  assign k_pusch   = PUSCH_K[tdd_config_r][sf_r];
  // The 10240 wrap keeps the subframe, so track it modulo 10 directly.
  assign sf_up_sum = 5'(sf_r) + 5'(k_pusch);
  assign sf_up     = (sf_up_sum >= 5'd10) ? 4'(sf_up_sum - 5'd10) : sf_up_sum[3:0];
  assign k_phich   = PHICH_K[tdd_config_r][sf_up];
  assign delta     = (frame_type_r == FRAME_FDD) ? fdd_ack_delay_r
                                                 : 4'(k_pusch) + 4'(k_phich);

  assign tti_sum     = (TTI_W + 1)'(tti_r) + (TTI_W + 1)'(delta);
  assign tti_wrapped = tti_sum >= TTI_WRAP;
  assign next_tti_c  = tti_wrapped ? TTI_W'(tti_sum - TTI_WRAP) : tti_sum[TTI_W-1:0];

  // Advance the slot by delta, then pull back by 10240 mod depth on a wrap.
  assign ns_a0 = (SW + 2)'(slot_r) + (SW + 2)'(delta);
  assign ns_a1 = (ns_a0 >= (SW + 2)'(TABLE_DEPTH)) ? ns_a0 - (SW + 2)'(TABLE_DEPTH) : ns_a0;
  assign ns_a2 = (ns_a1 >= (SW + 2)'(TABLE_DEPTH)) ? ns_a1 - (SW + 2)'(TABLE_DEPTH) : ns_a1;
  assign ns_b0 = ns_a2 + (tti_wrapped ? (SW + 2)'(AdjWrap) : '0);
  assign ns_b1 = (ns_b0 >= (SW + 2)'(TABLE_DEPTH)) ? ns_b0 - (SW + 2)'(TABLE_DEPTH) : ns_b0;
  assign next_slot = ns_b1[SW-1:0];

  // ---------------------------------------------------------------------------
  // Operation
  // ---------------------------------------------------------------------------
  logic             handled_c;
  logic             rearmed_c;
  logic [TTI_W-1:0] next_tti_out;

  always_comb begin
    flags_nxt    = flags_r;
    written_nxt  = written_r;
    wr_en_c      = 1'b0;
    wr_addr_c    = slot_r;
    wr_data_c    = {prb_r, dmrs_r};
    handled_c    = 1'b0;
    rearmed_c    = 1'b0;
    next_tti_out = '0;
    unique case (op_r)
      OP_ARM: begin
        flags_nxt[slot_r]   = 1'b1;
        written_nxt[slot_r] = 1'b1;
        wr_en_c             = 1'b1;
      end
      OP_CLEAR: begin
        flags_nxt[slot_r] = 1'b0;
      end
      OP_QUERY: begin
        // report only
      end
      OP_PHICH: begin
        if (was_armed) begin
          if (!err_r) begin
            handled_c = 1'b1;
            if (!ack_r) begin
              next_tti_out           = next_tti_c;
              flags_nxt[next_slot]   = 1'b1;
              written_nxt[next_slot] = 1'b1;
              wr_en_c                = 1'b1;
              wr_addr_c              = next_slot;
              wr_data_c              = old_entry;
              rearmed_c              = next_slot != slot_r;
            end
          end
          // the clear lands after the re-arm, so it wins on the same slot
          flags_nxt[slot_r] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  out_beat_t out_data_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r.pad           <= '0;
      out_data_r.entry_pending <= was_armed;
      out_data_r.stored_prb    <= old_entry[ENTRY_W-1:DMRS_W];
      out_data_r.stored_dmrs   <= old_entry[DMRS_W-1:0];
      out_data_r.handled       <= handled_c;
      out_data_r.rearmed       <= rearmed_c;
      out_data_r.next_tti      <= next_tti_out;
      out_data_r.any_pending   <= |flags_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `PPAT_ASSERT_SAME(a_rearm_needs_handled, out_valid_r && out_data_r.rearmed, out_data_r.handled, "rearmed without handled")
  `PPAT_ASSERT_NEXT(a_phich_clears_slot, advance && (op_r == OP_PHICH), !flags_r[$past(slot_r)], "PHICH outcome left its slot armed")
  `PPAT_ASSERT_NEXT(a_any_matches_flags, advance, out_data_r.any_pending == (|flags_r), "any_pending disagrees with table")
  `PPAT_ASSERT_SAME(a_stall_only_when_full, !in_tready, s1_valid_r && out_valid_r && !out_tready, "input stalled without backpressure")

endmodule
